// ===== hdl/hgpg_pkg.sv =====
// ============================================================================
// hgpg_pkg
// Shared types and constants for the hue gradient pixel generator.
// ============================================================================
`default_nettype none

package hgpg_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SATURATION  = 2'd0,
    CFG_VALUE_BASE  = 2'd1,
    CFG_VALUE_SLOPE = 2'd2
  } cfg_idx_e;

  // Reset values of the configuration registers (Q0.16)
  localparam logic [15:0] SATURATION_RST  = 16'd65535;
  localparam logic [15:0] VALUE_BASE_RST  = 16'd39322;
  localparam logic [15:0] VALUE_SLOPE_RST = 16'd26214;

  // Alpha is always opaque
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Hue sectors of the six-sector rule
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } hue_sector_e;

endpackage

`default_nettype wire

// ===== hdl/hgpg_to_byte.sv =====
// ============================================================================
// hgpg_to_byte
// Scales a Q0.16 level to an 8-bit channel: (level * 255) >> 16, truncated.
// ============================================================================
`default_nettype none

module hgpg_to_byte (
  input  logic [15:0] level_i,
  output logic [7:0]  byte_o
);

  logic [23:0] scaled;

  // x*255 = (x << 8) - x, never negative
  assign scaled = {level_i, 8'h00} - {8'h00, level_i};
  assign byte_o = scaled[23:16];

endmodule

`default_nettype wire

// ===== hdl/hue_gradient_pixel_generator.sv =====
// ============================================================================
// hue_gradient_pixel_generator
// Per-pixel HSV gradient test pattern: hue from column, row and phase,
// brightness ramp over the rows, six-sector HSV to RGB, 8-bit channels.
// ============================================================================
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in      | in_valid_i/in_stall_o | pixel_x_i, pixel_y_i, phase_i
//  out     | out_valid_o/out_stall_i | red_o, green_o, blue_o, alpha_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One word in and one word out per clock while the output is not stalled;
//  words pass through six register stages (table lookup, reciprocal multiply,
//  remainder fix, chroma multiply, ramp multiply, channel scaling).
//  Reset clears every stage valid bit and loads the register defaults.
//  A stall holds only the stages that are full behind a full stage; empty
//  stages keep filling, so an input word is taken while a result waits.
//  Config writes are always ready.
//
`default_nettype none

module hue_gradient_pixel_generator
  import hgpg_pkg::*;
#(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input pixel words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [15:0] phase_i,
  // output color words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int          NSTG      = 6;
  localparam int          HW        = $clog2(FRAME_HEIGHT + 1);
  localparam logic [HW-1:0] HEIGHT_C = HW'(FRAME_HEIGHT);
  // floor(2^24 / H); product slope*y stays below 2^24, so error is at most one
  localparam logic [23:0] RECIP     = 24'((64'd1 << 24) / FRAME_HEIGHT);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] saturation_q, value_base_q, value_slope_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saturation_q  <= SATURATION_RST;
      value_base_q  <= VALUE_BASE_RST;
      value_slope_q <= VALUE_SLOPE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SATURATION:  saturation_q  <= cfg_data_i;
        CFG_VALUE_BASE:  value_base_q  <= cfg_data_i;
        CFG_VALUE_SLOPE: value_slope_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage valid bits and per-stage ready chain
  // --------------------------------------------------------------------------
  logic [NSTG:1] vld_q;
  logic [NSTG:1] rdy;
  logic [NSTG:0] vld_in;

  assign vld_in = {vld_q, in_valid_i};

  always_comb begin
    rdy[NSTG] = !vld_q[NSTG] || !out_stall_i;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) vld_q[k] <= vld_in[k-1];
      end
    end
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = vld_q[NSTG];

  // --------------------------------------------------------------------------
  // Hue offset tables: x*65536/W and y*32768/H, low 16 bits
  // --------------------------------------------------------------------------
  logic [15:0] hx_tab [256];
  logic [15:0] hy_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_tab
    localparam int HX = (g * 65536) / FRAME_WIDTH;
    localparam int HY = (g * 32768) / FRAME_HEIGHT;
    assign hx_tab[g] = 16'(HX);
    assign hy_tab[g] = 16'(HY);
  end

  // --------------------------------------------------------------------------
  // Stage 1: hue sum, slope * row
  // --------------------------------------------------------------------------
  logic [15:0] hue1_d, hue1_q;
  logic [23:0] prod1_d, prod1_q;

  assign hue1_d  = hx_tab[pixel_x_i] + hy_tab[pixel_y_i] + phase_i;
  assign prod1_d = 24'(value_slope_q) * 24'(pixel_y_i);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      hue1_q  <= hue1_d;
      prod1_q <= prod1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sector split, reciprocal estimate of prod / H
  // --------------------------------------------------------------------------
  logic [18:0]  hh2;
  logic [47:0]  qest2;
  hue_sector_e  sector2_q;
  logic [15:0]  frac2_q;
  logic [23:0]  quot2_d, quot2_q;
  logic [23:0]  prod2_q;

  assign hh2     = 19'(hue1_q) * 19'd6;
  assign qest2   = 48'(prod1_q) * 48'(RECIP);
  assign quot2_d = qest2[47:24];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      sector2_q <= hue_sector_e'(hh2[18:16]);
      frac2_q   <= hh2[15:0];
      quot2_q   <= quot2_d;
      prod2_q   <= prod1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: remainder fix, brightness with saturation, ramp fraction
  // --------------------------------------------------------------------------
  logic [23+HW:0] qh3;
  logic [23:0]    rem3;
  logic [23:0]    quot3;
  logic [24:0]    vsum3;
  logic [15:0]    val3_d, val3_q;
  logic [16:0]    fsel3_d, fsel3_q;
  hue_sector_e    sector3_q;

  assign qh3   = {{HW{1'b0}}, quot2_q} * {24'h0, HEIGHT_C};
  assign rem3  = prod2_q - qh3[23:0];
  assign quot3 = quot2_q + 24'(rem3 >= 24'(HEIGHT_C));
  assign vsum3 = 25'(value_base_q) + 25'(quot3);
  assign val3_d = (vsum3[24:16] != '0) ? 16'hFFFF : vsum3[15:0];

  // odd sectors ramp down
  assign fsel3_d = sector2_q[0] ? (17'h10000 - 17'(frac2_q)) : 17'(frac2_q);

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      val3_q    <= val3_d;
      fsel3_q   <= fsel3_d;
      sector3_q <= sector2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: chroma = value * saturation
  // --------------------------------------------------------------------------
  logic [31:0]  cv4;
  logic [15:0]  chroma4_q, val4_q;
  logic [16:0]  fsel4_q;
  hue_sector_e  sector4_q;

  assign cv4 = 32'(val3_q) * 32'(saturation_q);

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      chroma4_q <= cv4[31:16];
      val4_q    <= val3_q;
      fsel4_q   <= fsel3_q;
      sector4_q <= sector3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: ramp component and minimum level
  // --------------------------------------------------------------------------
  logic [32:0]  xc5;
  logic [15:0]  ramp5_q, chroma5_q, min5_q;
  hue_sector_e  sector5_q;

  assign xc5 = 33'(chroma4_q) * 33'(fsel4_q);

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      ramp5_q   <= xc5[31:16];
      chroma5_q <= chroma4_q;
      min5_q    <= val4_q - chroma4_q;
      sector5_q <= sector4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: sector mapping and 8-bit scaling
  // --------------------------------------------------------------------------
  logic [15:0] rc, gc, bc;
  logic [15:0] rl, gl, bl;
  logic [7:0]  red_d, green_d, blue_d;
  logic [7:0]  red_q, green_q, blue_q;

  always_comb begin
    case (sector5_q)
      SEC_RED: begin
        rc = chroma5_q; gc = ramp5_q;   bc = '0;
      end
      SEC_YELLOW: begin
        rc = ramp5_q;   gc = chroma5_q; bc = '0;
      end
      SEC_GREEN: begin
        rc = '0;        gc = chroma5_q; bc = ramp5_q;
      end
      SEC_CYAN: begin
        rc = '0;        gc = ramp5_q;   bc = chroma5_q;
      end
      SEC_BLUE: begin
        rc = ramp5_q;   gc = '0;        bc = chroma5_q;
      end
      default: begin
        rc = chroma5_q; gc = '0;        bc = ramp5_q;
      end
    endcase
  end

  // component + min never exceeds the value
  assign rl = rc + min5_q;
  assign gl = gc + min5_q;
  assign bl = bc + min5_q;

  hgpg_to_byte u_red   (.level_i(rl), .byte_o(red_d));
  hgpg_to_byte u_green (.level_i(gl), .byte_o(green_d));
  hgpg_to_byte u_blue  (.level_i(bl), .byte_o(blue_d));

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign alpha_o = ALPHA_OPAQUE;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[1])
    else $error("accepted word did not reach stage 1");

  a_full_pipe_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q == '1 && out_stall_i) |-> in_stall_o)
    else $error("input taken while pipeline full and output stalled");

  a_sector_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (sector2_q <= SEC_MAGENTA))
    else $error("hue sector out of range");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (qh3[23:0] <= prod2_q) && (rem3 < (24'(HEIGHT_C) << 1)))
    else $error("reciprocal estimate off by more than one");

  a_ramp_le_chroma : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (ramp5_q <= chroma5_q) && (32'(min5_q) + 32'(chroma5_q) <= 32'hFFFF))
    else $error("ramp component exceeds chroma");

endmodule

`default_nettype wire

// ===== verif/hgpg_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel color checker for the hue gradient pixel generator
// Watches the pixel, color and register channels, predicts the RGBA word
// for every accepted pixel and compares each color word with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hgpg_pixel_checker
  import hgpg_pkg::*;
#(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [15:0] phase_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // local copy of the register file
  logic [15:0] sat_q;
  logic [15:0] base_q;
  logic [15:0] slope_q;

  rgba_t expected_colors[$];

  // Q0.16 level to 8-bit channel, truncated
  function automatic logic [7:0] to_channel(input logic [31:0] level);
    logic [31:0] scaled;
    scaled = (level * 32'd255) >> 16;
    return scaled[7:0];
  endfunction

  // hue from position and phase, brightness ramp over rows, six-sector rule
  function automatic rgba_t shade_pixel(input logic [7:0] col, input logic [7:0] row,
                                        input logic [15:0] shift);
    logic [31:0] hue_x, hue_y, hue, bright, chroma, floor_lvl;
    logic [31:0] hue6, frac, ramp, r, g, b;
    hue_sector_e sector;
    rgba_t px;
    hue_x = (32'(col) * 32'd65536) / 32'(FRAME_WIDTH);
    hue_y = (32'(row) * 32'd32768) / 32'(FRAME_HEIGHT);
    hue   = (hue_x + hue_y + 32'(shift)) & 32'hFFFF;
    bright = 32'(base_q) + (32'(slope_q) * 32'(row)) / 32'(FRAME_HEIGHT);
    if (bright > 32'hFFFF) begin
      bright = 32'hFFFF;
    end
    chroma    = (bright * 32'(sat_q)) >> 16;
    floor_lvl = bright - chroma;
    hue6   = hue * 32'd6;
    sector = hue_sector_e'(hue6[18:16]);
    frac   = hue6 & 32'hFFFF;
    // odd sectors fall, even sectors rise
    ramp = hue6[16] ? (chroma * (32'd65536 - frac)) >> 16 : (chroma * frac) >> 16;
    case (sector)
      SEC_RED: begin
        r = chroma; g = ramp; b = 0;
      end
      SEC_YELLOW: begin
        r = ramp; g = chroma; b = 0;
      end
      SEC_GREEN: begin
        r = 0; g = chroma; b = ramp;
      end
      SEC_CYAN: begin
        r = 0; g = ramp; b = chroma;
      end
      SEC_BLUE: begin
        r = ramp; g = 0; b = chroma;
      end
      default: begin
        r = chroma; g = 0; b = ramp;
      end
    endcase
    px.red   = to_channel(r + floor_lvl);
    px.green = to_channel(g + floor_lvl);
    px.blue  = to_channel(b + floor_lvl);
    px.alpha = ALPHA_OPAQUE;
    return px;
  endfunction

  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count_o++;
    end
  endtask

  // Sampled at the falling edge: every handshake seen here completes at the
  // next rising edge, since inputs and outputs only move on rising edges.
  always @(negedge clk_i or negedge rst_ni) begin
    rgba_t want;
    if (!rst_ni) begin
      sat_q   = SATURATION_RST;
      base_q  = VALUE_BASE_RST;
      slope_q = VALUE_SLOPE_RST;
      expected_colors.delete();
      error_count_o = 0;
    end else begin
      // predict with the registers as they stand before any write
      if (in_valid_i && !in_stall_i) begin
        expected_colors.push_back(shade_pixel(pixel_x_i, pixel_y_i, phase_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected color word r=%0d g=%0d b=%0d a=%0d",
                   $time, red_i, green_i, blue_i, alpha_i);
          error_count_o++;
        end else begin
          want = expected_colors.pop_front();
          check_channel("red",   want.red,   red_i);
          check_channel("green", want.green, green_i);
          check_channel("blue",  want.blue,  blue_i);
          check_channel("alpha", want.alpha, alpha_i);
        end
      end
      // register writes; unknown index is dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SATURATION:  sat_q   = cfg_data_i;
          CFG_VALUE_BASE:  base_q  = cfg_data_i;
          CFG_VALUE_SLOPE: slope_q = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_colors.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the hue gradient pixel generator
// Drives pixel words and register settings with random gaps and output
// stalls; a checker beside the block predicts and compares every color word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import hgpg_pkg::*;
();

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 24;
  localparam logic [1:0]  CFG_UNMAPPED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  pixel_x_i;
  logic [7:0]  pixel_y_i;
  logic [15:0] phase_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  int unsigned error_count;
  int unsigned pending;
  int unsigned cycles = 0;
  bit          quiet;

  hue_gradient_pixel_generator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .phase_i    (phase_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .alpha_o    (alpha_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  hgpg_pixel_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .phase_i      (phase_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .alpha_i      (alpha_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hue_gradient_pixel_generator verification failed");
      $finish;
    end
  end

  // Color sink: stalls a random number of cycles before each word.
  initial begin : color_sink
    int unsigned hold;
    bit          taken;
    out_stall_i = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  // Called right after a rising edge; leaves valid high once accepted.
  task automatic send_pixel(input logic [7:0] col, input logic [7:0] row,
                            input logic [15:0] shift);
    int unsigned gap;
    bit          taken;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i  <= col;
    pixel_y_i  <= row;
    phase_i    <= shift;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Holds cfg_valid_i high across back-to-back writes; caller lowers it.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // New register setting, plus a write to the unmapped index that must be dropped
  task automatic program_regs(input logic [15:0] sat, input logic [15:0] base,
                              input logic [15:0] slope);
    wait_drained();
    write_reg(CFG_SATURATION, sat);
    write_reg(CFG_VALUE_BASE, base);
    write_reg(CFG_VALUE_SLOPE, slope);
    write_reg(CFG_UNMAPPED, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Random pixels; stretches of back-to-back traffic come and go
  task automatic send_random(input int unsigned count);
    logic [7:0]  col, row;
    logic [15:0] shift;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      col   = 8'($urandom);
      row   = 8'($urandom);
      shift = 16'($urandom);
      // occasional frame corners and phase extremes
      case ($urandom_range(0, 11))
        0: col = 8'($urandom_range(0, 1) ? 255 : 0);
        1: row = 8'($urandom_range(0, 1) ? 255 : 0);
        2: shift = 16'($urandom_range(0, 1) ? 65535 : 0);
        default: ;
      endcase
      send_pixel(col, row, shift);
    end
    quiet = 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    pixel_x_i   = '0;
    pixel_y_i   = '0;
    phase_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting first, untouched
    send_pixel(8'd0,   8'd0,   16'd0);
    send_pixel(8'd255, 8'd255, 16'd65535);
    send_pixel(8'd255, 8'd0,   16'd0);
    send_pixel(8'd0,   8'd255, 16'd0);
    // walk the phase across every sector and its boundaries
    send_pixel(8'd0,   8'd0,   16'd10922);
    send_pixel(8'd0,   8'd0,   16'd10923);
    send_pixel(8'd0,   8'd0,   16'd21845);
    send_pixel(8'd0,   8'd0,   16'd21846);
    send_pixel(8'd0,   8'd0,   16'd32768);
    send_pixel(8'd0,   8'd0,   16'd43690);
    send_pixel(8'd0,   8'd0,   16'd43691);
    send_pixel(8'd0,   8'd0,   16'd54613);
    send_pixel(8'd0,   8'd0,   16'd54614);
    send_pixel(8'd0,   8'd0,   16'd65535);
    // hue from column and row plus phase, the first two wrapping
    send_pixel(8'd128, 8'd128, 16'd32768);
    send_pixel(8'd170, 8'd200, 16'd50000);
    send_pixel(8'd85,  8'd1,   16'd1);

    program_regs(SATURATION_RST, VALUE_BASE_RST, VALUE_SLOPE_RST);
    send_random(80);

    // brightness saturates: full value maps to channel 254
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(8'd0,   8'd0,   16'd0);
    send_pixel(8'd0,   8'd255, 16'd21846);
    send_pixel(8'd255, 8'd255, 16'd43691);
    send_random(70);

    // grey scale
    program_regs(16'd0, 16'd32768, 16'hFFFF);
    send_random(60);

    // black
    program_regs(16'd0, 16'd0, 16'd0);
    send_random(40);

    program_regs(16'd1, 16'd1, 16'd1);
    send_random(40);

    program_regs(16'hFFFF, 16'd0, 16'hFFFF);
    send_random(40);

    for (int k = 0; k < 3; k++) begin
      program_regs(16'($urandom), 16'($urandom), 16'($urandom));
      send_random(45);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("hue_gradient_pixel_generator verification clean");
    end else begin
      $display("hue_gradient_pixel_generator verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hgpg_pkg.sv
hdl/hgpg_to_byte.sv
hdl/hue_gradient_pixel_generator.sv
verif/hgpg_pixel_checker.sv
verif/testbench.sv
